### sv/selection_sort_engine_core_defines.svh
`ifndef SELECTION_SORT_ENGINE_CORE_DEFINES_SVH
`define SELECTION_SORT_ENGINE_CORE_DEFINES_SVH

// same-cycle implication under reset
`define SSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sse_pkg.sv
package sse_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int DATA_W = 32;
    localparam int APB_AW = 3;

    // register index taken from paddr[2]
    localparam logic REG_DESCENDING = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READI,
        S_FIRST,
        S_SCAN,
        S_EMIT
    } sse_state_t;

endpackage

### sv/sse_store.sv
module sse_store #(
    parameter int DEPTH = sse_pkg::MAX_ITEMS_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [sse_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [sse_pkg::DATA_W-1:0] rdata
);

    logic [sse_pkg::DATA_W-1:0] mem [DEPTH];
    logic [sse_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sse_cmp.sv
module sse_cmp (
    input  logic signed [sse_pkg::DATA_W-1:0] best,
    input  logic signed [sse_pkg::DATA_W-1:0] cand,
    input  logic                              descending,
    output logic                              better
);

    always_comb
    begin
        if (descending)
        begin
            better = best < cand;
        end
        else
        begin
            better = cand < best;
        end
    end

endmodule

### sv/selection_sort_engine_core.sv
// throughput: one input item per cycle while loading
// one shared signed comparator and a store with one write and one registered read port set the pace
// no input item is taken while a set is being sorted and emitted
// reset: async active low, clears sequencer, count, overflow flag and descending; store is not cleared
module selection_sort_engine_core #(
    parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sse_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [sse_pkg::DATA_W-1:0] value,
    input  logic                              last,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [sse_pkg::DATA_W-1:0] sorted_value,
    output logic                              end_of_set,
    output logic                              overflow
);

`include "selection_sort_engine_core_defines.svh"

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    sse_pkg::sse_state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic                      ovf_reg, ovf_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic [sse_pkg::DATA_W-1:0] best_reg, best_next;
    logic [sse_pkg::DATA_W-1:0] vali_reg, vali_next;
    logic                      desc_reg;
    logic                      result_valid_reg, result_valid_next;
    logic [sse_pkg::DATA_W-1:0] sorted_value_reg;
    logic                      end_of_set_reg;
    logic                      overflow_reg;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [sse_pkg::DATA_W-1:0] mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic [sse_pkg::DATA_W-1:0] mem_rdata;

    logic better;
    logic out_load;
    logic last_pass;
    logic emit_ok;
    logic cfg_write;

    sse_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sse_cmp u_cmp (
        .best       (best_reg),
        .cand       (mem_rdata),
        .descending (desc_reg),
        .better     (better)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == sse_pkg::REG_DESCENDING);

    always_comb
    begin
        if (paddr[2] == sse_pkg::REG_DESCENDING)
        begin
            prdata = {31'b0, desc_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            desc_reg <= pwdata[0];
        end
    end

    assign emit_ok   = !result_valid_reg || !result_stall;
    assign last_pass = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        n_next            = n_reg;
        ovf_next          = ovf_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        pick_next         = pick_reg;
        best_next         = best_reg;
        vali_next         = vali_reg;
        result_valid_next = result_valid_reg && result_stall;
        out_load          = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = i_reg;
        mem_wdata         = value;
        mem_raddr         = i_reg;

        unique case (state_reg)
            sse_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next     = count_next;
                        i_next     = '0;
                        state_next = sse_pkg::S_READI;
                    end
                end
            end
            sse_pkg::S_READI:
            begin
                mem_raddr  = i_reg;
                state_next = sse_pkg::S_FIRST;
            end
            sse_pkg::S_FIRST:
            begin
                best_next = mem_rdata;
                vali_next = mem_rdata;
                pick_next = i_reg;
                if ((CNT_W'(i_reg) + CNT_W'(1)) < n_reg)
                begin
                    mem_raddr  = i_reg + IDX_W'(1);
                    j_next     = i_reg + IDX_W'(1);
                    state_next = sse_pkg::S_SCAN;
                end
                else
                begin
                    state_next = sse_pkg::S_EMIT;
                end
            end
            sse_pkg::S_SCAN:
            begin
                if (better)
                begin
                    best_next = mem_rdata;
                    pick_next = j_reg;
                end
                if ((CNT_W'(j_reg) + CNT_W'(1)) < n_reg)
                begin
                    mem_raddr = j_reg + IDX_W'(1);
                    j_next    = j_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = sse_pkg::S_EMIT;
                end
            end
            sse_pkg::S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_load          = 1'b1;
                    result_valid_next = 1'b1;
                    // swap: old head goes where the winner was
                    mem_we            = 1'b1;
                    mem_waddr         = pick_reg;
                    mem_wdata         = vali_reg;
                    if (last_pass)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = sse_pkg::S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = sse_pkg::S_READI;
                    end
                end
            end
            default:
            begin
                state_next = sse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sse_pkg::S_IDLE;
            count_reg        <= '0;
            n_reg            <= '0;
            ovf_reg          <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            pick_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            n_reg            <= n_next;
            ovf_reg          <= ovf_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            pick_reg         <= pick_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        vali_reg <= vali_next;
        if (out_load)
        begin
            sorted_value_reg <= best_reg;
            end_of_set_reg   <= last_pass;
            overflow_reg     <= ovf_reg;
        end
    end

    assign item_stall   = (state_reg != sse_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_of_set_reg;
    assign overflow     = overflow_reg;

    `SSE_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_MAX,
        "element count beyond capacity")
    `SSE_ASSERT_NOW(a_scan_bounds, clk, rst_n, state_reg == sse_pkg::S_SCAN,
        (j_reg > i_reg) && (CNT_W'(j_reg) < n_reg), "scan index out of range")
    `SSE_ASSERT_NEXT(a_end_to_idle, clk, rst_n,
        (state_reg == sse_pkg::S_EMIT) && emit_ok && last_pass,
        (state_reg == sse_pkg::S_IDLE) && end_of_set_reg && result_valid_reg,
        "final item of set not followed by idle")

endmodule
